// ----- rtl/lsgu_pkg.sv -----
package lsgu_pkg;

    localparam int LINE_LENGTH = 512;
    localparam int LINE_COUNT  = 512;
    localparam int POS_W       = $clog2(LINE_LENGTH);
    localparam int LINE_W      = $clog2(LINE_COUNT);
    localparam int STORE_DEPTH = 3 * LINE_LENGTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd3277;

    // Work handed from the front part to the back part.
    // A pass-through job carries its value in center; an update job also
    // carries the four neighbors.
    typedef struct packed {
        logic                       update;
        logic signed [SAMPLE_W-1:0] center;
        logic signed [SAMPLE_W-1:0] north;
        logic signed [SAMPLE_W-1:0] south;
        logic signed [SAMPLE_W-1:0] east;
        logic signed [SAMPLE_W-1:0] west;
        logic                       run_last;
        logic                       frame_end;
    } job_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] new_value;
        logic                       run_last;
        logic                       frame_end;
    } result_t;

endpackage

// ----- rtl/lsgu_ram.sv -----
module lsgu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- rtl/lsgu_queue.sv -----
module lsgu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lsgu_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output lsgu_pkg::job_t pop_data,
    output logic          empty
);
    import lsgu_pkg::*;

    job_t       slot_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;

    assign full     = cnt_reg == 3'd4;
    assign empty    = cnt_reg == 3'd0;
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop && !empty)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, push && !full} - {2'd0, pop && !empty};
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> cnt_reg != 3'd0)
        else $error("full queue drained too fast");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[1:0] == wr_reg - rd_reg))
        else $error("queue pointers disagree with count");
endmodule

// ----- rtl/lsgu_front.sv -----
module lsgu_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [lsgu_pkg::SAMPLE_W-1:0] sample,
    output logic                                job_push,
    output lsgu_pkg::job_t                      job_data,
    input  logic                                job_full
);
    import lsgu_pkg::*;

    // Sequencer steps for one input item.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_RD3  = 3'd4;
    localparam logic [2:0] S_RD4  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_PASS = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [POS_W-1:0]    pos_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [1:0]          slot_reg;
    logic signed [SAMPLE_W-1:0] raw_reg;
    job_t                job_reg;

    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [SAMPLE_W-1:0] rdata;
    logic [1:0]          slot_prev, slot_next_line;
    logic [POS_W-1:0]    east, west;
    logic                last_line, last_pos;

    lsgu_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(sample),
        .re(re), .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] s, input logic [POS_W-1:0] p);
        return ADDR_W'(s) * ADDR_W'(LINE_LENGTH) + ADDR_W'(p);
    endfunction

    assign last_line = line_reg == LINE_W'(LINE_COUNT - 1);
    assign last_pos  = pos_reg == POS_W'(LINE_LENGTH - 1);
    assign east      = last_pos ? '0 : pos_reg + POS_W'(1);
    assign west      = (pos_reg == '0) ? POS_W'(LINE_LENGTH - 1) : pos_reg - POS_W'(1);
    // Current line c sits in slot_reg; line c-1 (the one updated) and c-2.
    assign slot_prev      = (slot_reg == 2'd0) ? 2'd2 : slot_reg - 2'd1;
    assign slot_next_line = (slot_prev == 2'd0) ? 2'd2 : slot_prev - 2'd1;

    assign full  = state_reg != S_IDLE;
    assign we    = push && !full;
    assign waddr = addr_of(slot_reg, pos_reg);
    assign re    = 1'b1;

    always_comb
    begin
        unique case (state_reg)
            S_RD1:   raddr = addr_of(slot_prev, east);
            S_RD2:   raddr = addr_of(slot_prev, west);
            S_RD3:   raddr = addr_of(slot_next_line, pos_reg);
            default: raddr = addr_of(slot_prev, pos_reg);
        endcase
    end

    assign job_push = (state_reg == S_EMIT || state_reg == S_PASS) && !job_full;
    assign job_data = job_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (we)
                begin
                    state_next = (line_reg == '0) ? S_IDLE : S_RD0;
                end
            end
            S_RD0: state_next = S_RD1;
            S_RD1: state_next = S_RD2;
            S_RD2: state_next = S_RD3;
            S_RD3: state_next = S_RD4;
            S_RD4: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!job_full)
                begin
                    state_next = job_reg.run_last ? S_IDLE : S_PASS;
                end
            end
            S_PASS:
            begin
                if (!job_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            raw_reg <= sample;
        end
        // Read data appears in the cycle after its address.
        unique case (state_reg)
            S_RD1: job_reg.center <= rdata;
            S_RD2: job_reg.east   <= rdata;
            S_RD3: job_reg.west   <= rdata;
            S_RD4: job_reg.south  <= rdata;
            S_EMIT:
            begin
                if (!job_full)
                begin
                    job_reg.update    <= 1'b0;
                    job_reg.center    <= raw_reg;
                    job_reg.run_last  <= 1'b1;
                    job_reg.frame_end <= last_pos;
                end
            end
            S_IDLE:
            begin
                job_reg.update    <= line_reg != LINE_W'(1);
                job_reg.run_last  <= !last_line;
                job_reg.frame_end <= 1'b0;
                job_reg.north     <= sample;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            line_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_IDLE && we && line_reg == '0) ||
                (state_reg == S_EMIT && !job_full && job_reg.run_last) ||
                (state_reg == S_PASS && !job_full))
            begin
                if (last_pos)
                begin
                    pos_reg  <= '0;
                    line_reg <= last_line ? '0 : line_reg + LINE_W'(1);
                    slot_reg <= last_line ? 2'd0 : ((slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1);
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    a_pass_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PASS |-> last_line)
        else $error("second result outside the last line");
    a_first_line_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && line_reg == '0) |-> !job_push)
        else $error("job pushed during the first line");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n) slot_reg != 2'd3)
        else $error("line slot out of range");
endmodule

// ----- rtl/lsgu_back.sv -----
module lsgu_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lsgu_pkg::GAIN_W-1:0]       gain,
    input  logic                              job_empty,
    input  lsgu_pkg::job_t                    job_data,
    output logic                              job_pop,
    output logic                              busy,
    output logic                              empty,
    input  logic                              pop,
    output lsgu_pkg::result_t                 result
);
    import lsgu_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SQ   = 3'd1;
    localparam logic [2:0] B_ROOT = 3'd2;
    localparam logic [2:0] B_MUL  = 3'd3;
    localparam logic [2:0] B_SUB  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]  state_reg;
    job_t        job_reg;
    logic signed [SAMPLE_W:0] dn_reg, de_reg;
    logic [33:0] rem_reg;
    logic [16:0] root_reg;
    logic [4:0]  step_reg;
    logic [33:0] prod_reg;
    logic [33:0] val_reg;
    result_t     res_reg;

    logic [33:0] sq_sum, trial;
    logic signed [17:0] diff;

    assign job_pop = state_reg == B_IDLE && !job_empty;
    assign empty   = state_reg != B_OUT;
    assign busy    = state_reg != B_IDLE;
    assign result  = res_reg;

    assign sq_sum = 34'(dn_reg * dn_reg) + 34'(de_reg * de_reg);
    // One root bit per cycle: restoring square root, 17 steps.
    assign trial       = {15'd0, root_reg, 2'b01};
    assign diff        = 18'(job_reg.center) - 18'($signed({1'b0, prod_reg[32:16]}));

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_reg <= job_data;
                    dn_reg  <= 17'(job_data.north) - 17'(job_data.south);
                    de_reg  <= 17'(job_data.east) - 17'(job_data.west);
                end
            end
            B_SQ:
            begin
                val_reg  <= sq_sum;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= 5'd17;
            end
            B_ROOT:
            begin
                if ({rem_reg[31:0], val_reg[33:32]} >= trial)
                begin
                    rem_reg  <= {rem_reg[31:0], val_reg[33:32]} - trial;
                    root_reg <= {root_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= {rem_reg[31:0], val_reg[33:32]};
                    root_reg <= {root_reg[15:0], 1'b0};
                end
                val_reg  <= {val_reg[31:0], 2'b00};
                step_reg <= step_reg - 5'd1;
            end
            B_MUL:
            begin
                prod_reg <= 34'({1'b0, gain} * root_reg) + 34'd32768;
            end
            B_SUB:
            begin
                res_reg.run_last  <= job_reg.run_last;
                res_reg.frame_end <= job_reg.frame_end;
                if (!job_reg.update)
                begin
                    res_reg.new_value <= job_reg.center;
                end
                else if (prod_reg[33] || diff < -18'sd32768)
                begin
                    res_reg.new_value <= 16'sh8000;
                end
                else
                begin
                    res_reg.new_value <= diff[15:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:  if (!job_empty) state_reg <= B_SQ;
                B_SQ:    state_reg <= B_ROOT;
                B_ROOT:  if (step_reg == 5'd1) state_reg <= B_MUL;
                B_MUL:   state_reg <= B_SUB;
                B_SUB:   state_reg <= B_OUT;
                B_OUT:   if (pop) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ROOT |-> step_reg != 5'd0)
        else $error("root iteration ran past its last step");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && !pop) |=> state_reg == B_OUT && $stable(res_reg))
        else $error("result changed while waiting");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> state_reg == B_IDLE)
        else $error("job taken while busy");
endmodule

// ----- rtl/level_set_gradient_update_unit.sv -----
// Results begin with the second line of samples; the first line only fills the line store.
// Flow: the front takes no new sample until its four line-store reads on one RAM port
// and its job hand-off are done; the back end's bit-serial root takes one job at a time.
// Reset: asynchronous, active low; clears counters and queue and sets gain to 3277.
// The line store is not cleared; each entry is written before its value is used in a result.
module level_set_gradient_update_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [lsgu_pkg::SAMPLE_W-1:0] sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [lsgu_pkg::SAMPLE_W-1:0] new_value,
    output logic                                 run_last,
    output logic                                 frame_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsgu_pkg::GAIN_W-1:0]          cfg_data
);
    import lsgu_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    job_t    fj_data, bj_data;
    logic    fj_push, fj_full, bj_pop, bj_empty, back_busy;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            gain_reg <= cfg_data;
        end
    end

    lsgu_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .sample(sample),
        .job_push(fj_push), .job_data(fj_data), .job_full(fj_full)
    );

    lsgu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(fj_push), .push_data(fj_data), .full(fj_full),
        .pop(bj_pop), .pop_data(bj_data), .empty(bj_empty)
    );

    lsgu_back u_back (
        .clk(clk), .rst_n(rst_n), .gain(gain_reg), .job_empty(bj_empty),
        .job_data(bj_data), .job_pop(bj_pop), .busy(back_busy), .empty(empty),
        .pop(pop), .result(res)
    );

    assign new_value = res.new_value;
    assign run_last  = res.run_last;
    assign frame_end = res.frame_end;

    a_empty_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> back_busy)
        else $error("result shown while back end idle");
endmodule
